/* sv/depth_pixel_backprojection_unit_assert.svh */
// assertion macros used by the checker file
`ifndef DEPTH_PIXEL_BACKPROJECTION_UNIT_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define DPBP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dpbp assertion failed");

// next-cycle implication, disabled while reset is low
`define DPBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dpbp assertion failed");

`endif

/* sv/dpbp_pkg.sv */
// package: constants and types of the depth pixel back-projection unit
`timescale 1ns / 1ps
package dpbp_pkg;

    localparam int CENTER_W = 16;
    localparam int RECIP_W  = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int XY_W     = 36;
    localparam int Z_OUT_W  = 16;
    localparam int Q_SHIFT  = 24;
    localparam int LATENCY  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_Y  = 3'd3;

    localparam logic [CENTER_W-1:0] CENTER_X_RST = 16'd5120;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = 16'd3840;
    localparam logic [RECIP_W-1:0]  RECIP_X_RST  = 24'd31957;
    localparam logic [RECIP_W-1:0]  RECIP_Y_RST  = 24'd31957;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color;

endpackage

/* sv/dpbp_axis.sv */
// one projection axis: floor(((coord << 4) - center) * depth * recip / 2^24), four stages
`timescale 1ns / 1ps
module dpbp_axis #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  logic                                i_clk,
    input  logic [COORD_BITS-1:0]               i_coord,
    input  logic [DEPTH_BITS-1:0]               i_depth,
    input  logic [dpbp_pkg::CENTER_W-1:0]       i_center,
    input  logic [dpbp_pkg::RECIP_W-1:0]        i_recip,
    output logic [dpbp_pkg::XY_W-1:0]           o_coord_q4
);

    localparam int POS_W  = COORD_BITS + 4;
    localparam int DIFF_W = ((POS_W > dpbp_pkg::CENTER_W) ? POS_W : dpbp_pkg::CENTER_W) + 1;
    localparam int Z_W    = DEPTH_BITS + 1;
    localparam int P1_W   = DIFF_W + Z_W;
    localparam int LO_W   = dpbp_pkg::RECIP_W / 2;
    localparam int HI_W   = dpbp_pkg::RECIP_W - LO_W;
    localparam int PLO_W  = P1_W + LO_W + 1;
    localparam int PHI_W  = P1_W + HI_W + 1;
    localparam int FULL_W = P1_W + dpbp_pkg::RECIP_W + 1;
    localparam int SUM_W  = (FULL_W > dpbp_pkg::Q_SHIFT + dpbp_pkg::XY_W) ?
                            FULL_W : dpbp_pkg::Q_SHIFT + dpbp_pkg::XY_W;

    logic        [DIFF_W-1:0] w_pos;
    logic        [DIFF_W-1:0] w_ctr;
    logic signed [LO_W:0]     w_rlo;
    logic signed [HI_W:0]     w_rhi;
    logic signed [SUM_W-1:0]  w_lo_ext;
    logic signed [SUM_W-1:0]  w_hi_ext;
    logic signed [SUM_W-1:0]  w_sum;

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [Z_W-1:0]    r_z;
    logic signed [P1_W-1:0]   r_p1;
    logic signed [PLO_W-1:0]  r_plo;
    logic signed [PHI_W-1:0]  r_phi;
    logic [dpbp_pkg::XY_W-1:0] r_out;

    assign w_pos = DIFF_W'({i_coord, 4'b0000});
    assign w_ctr = DIFF_W'(i_center);
    assign w_rlo = $signed({1'b0, i_recip[LO_W-1:0]});
    assign w_rhi = $signed({1'b0, i_recip[dpbp_pkg::RECIP_W-1:LO_W]});

    // signed casts keep the sign while widening
    assign w_lo_ext = SUM_W'(r_plo);
    assign w_hi_ext = SUM_W'(r_phi);
    assign w_sum    = w_lo_ext + (w_hi_ext <<< LO_W);

    always_ff @(posedge i_clk) begin
        r_diff <= $signed(w_pos - w_ctr);
        r_z    <= $signed({1'b0, i_depth});
        r_p1   <= r_diff * r_z;
        // recip split in two halves to keep each multiplier narrow
        r_plo  <= r_p1 * w_rlo;
        r_phi  <= r_p1 * w_rhi;
        // arithmetic shift of the exact product gives floor
        r_out  <= w_sum[dpbp_pkg::Q_SHIFT +: dpbp_pkg::XY_W];
    end

    assign o_coord_q4 = r_out;

endmodule

/* sv/depth_pixel_backprojection_unit.sv */
// top level: depth pixel back-projection to a colored 3D point
//
//   channel   signals                                   direction
//   pixel     start, busy, i_pixel_*, i_depth_raw, i_*_in   in (busy: out)
//   point     o_strobe, o_point_*, o_*_out               out
//   config    i_cfg_we, i_cfg_idx, i_cfg_data           in
//
// one pixel per clock; the path from accept to o_strobe
// follows the x/y multiply chain: diff, depth product, recip partials, sum
// busy stays low, the pipeline never stalls and the receiver cannot hold results off
// synchronous reset clears the valid bits and loads the camera defaults
// a pixel with zero depth travels as an empty slot and gives no transaction
`timescale 1ns / 1ps
module depth_pixel_backprojection_unit #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [COORD_BITS-1:0]              i_pixel_column,
    input  logic [COORD_BITS-1:0]              i_pixel_row,
    input  logic [DEPTH_BITS-1:0]              i_depth_raw,
    input  logic [7:0]                         i_blue_in,
    input  logic [7:0]                         i_green_in,
    input  logic [7:0]                         i_red_in,
    input  logic                               i_cfg_we,
    input  logic [dpbp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dpbp_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                               o_strobe,
    output logic signed [dpbp_pkg::XY_W-1:0]   o_point_x_q4,
    output logic signed [dpbp_pkg::XY_W-1:0]   o_point_y_q4,
    output logic [dpbp_pkg::Z_OUT_W-1:0]       o_point_z,
    output logic [7:0]                         o_blue_out,
    output logic [7:0]                         o_green_out,
    output logic [7:0]                         o_red_out
);

    localparam int LAT = dpbp_pkg::LATENCY;

    logic [dpbp_pkg::CENTER_W-1:0] r_center_x;
    logic [dpbp_pkg::CENTER_W-1:0] r_center_y;
    logic [dpbp_pkg::RECIP_W-1:0]  r_recip_x;
    logic [dpbp_pkg::RECIP_W-1:0]  r_recip_y;

    logic [LAT-1:0]        r_vld;
    logic [LAT-1:0]        n_vld;
    logic [DEPTH_BITS-1:0] r_z_dly   [LAT];
    dpbp_pkg::t_color      r_col_dly [LAT];
    dpbp_pkg::t_color      w_col_in;

    logic [dpbp_pkg::XY_W-1:0] w_x;
    logic [dpbp_pkg::XY_W-1:0] w_y;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= dpbp_pkg::CENTER_X_RST;
            r_center_y <= dpbp_pkg::CENTER_Y_RST;
            r_recip_x  <= dpbp_pkg::RECIP_X_RST;
            r_recip_y  <= dpbp_pkg::RECIP_Y_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpbp_pkg::REG_CENTER_X: begin
                    r_center_x <= i_cfg_data[dpbp_pkg::CENTER_W-1:0];
                end
                dpbp_pkg::REG_CENTER_Y: begin
                    r_center_y <= i_cfg_data[dpbp_pkg::CENTER_W-1:0];
                end
                dpbp_pkg::REG_RECIP_X: begin
                    r_recip_x <= i_cfg_data[dpbp_pkg::RECIP_W-1:0];
                end
                dpbp_pkg::REG_RECIP_Y: begin
                    r_recip_y <= i_cfg_data[dpbp_pkg::RECIP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // zero depth enters as an empty slot
    assign n_vld = {r_vld[LAT-2:0], start & ~busy & (i_depth_raw != '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_col_in = '{blue: i_blue_in, green: i_green_in, red: i_red_in};

    always_ff @(posedge i_clk) begin
        r_z_dly[0]   <= i_depth_raw;
        r_col_dly[0] <= w_col_in;
        for (int i = 1; i < LAT; i++) begin
            r_z_dly[i]   <= r_z_dly[i-1];
            r_col_dly[i] <= r_col_dly[i-1];
        end
    end

    dpbp_axis #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_axis_x (
        .i_clk      (i_clk),
        .i_coord    (i_pixel_column),
        .i_depth    (i_depth_raw),
        .i_center   (r_center_x),
        .i_recip    (r_recip_x),
        .o_coord_q4 (w_x)
    );

    dpbp_axis #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_axis_y (
        .i_clk      (i_clk),
        .i_coord    (i_pixel_row),
        .i_depth    (i_depth_raw),
        .i_center   (r_center_y),
        .i_recip    (r_recip_y),
        .o_coord_q4 (w_y)
    );

    assign o_strobe     = r_vld[LAT-1];
    assign o_point_x_q4 = $signed(w_x);
    assign o_point_y_q4 = $signed(w_y);
    assign o_point_z    = dpbp_pkg::Z_OUT_W'(r_z_dly[LAT-1]);
    assign o_blue_out   = r_col_dly[LAT-1].blue;
    assign o_green_out  = r_col_dly[LAT-1].green;
    assign o_red_out    = r_col_dly[LAT-1].red;

endmodule

/* sv/dpbp_chk.sv */
// port checker for the back-projection unit and its bind
`timescale 1ns / 1ps
`include "depth_pixel_backprojection_unit_assert.svh"
module dpbp_chk #(
    parameter int DEPTH_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [DEPTH_BITS-1:0]         i_depth_raw,
    input logic [7:0]                    i_red_in,
    input logic                          o_strobe,
    input logic [dpbp_pkg::Z_OUT_W-1:0]  o_point_z,
    input logic [7:0]                    o_red_out
);

    localparam int LAT = dpbp_pkg::LATENCY;

    logic                         w_take;
    logic [dpbp_pkg::Z_OUT_W-1:0] w_z_in;

    // a transaction with a depth enters the pipeline
    assign w_take = start && !busy && (i_depth_raw != '0);
    assign w_z_in = dpbp_pkg::Z_OUT_W'(i_depth_raw);

    `DPBP_ASSERT_NEXT(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `DPBP_ASSERT_SAME(a_strobe_has_source, i_clk, i_rst_n, o_strobe, $past(w_take, LAT))
    `DPBP_ASSERT_SAME(a_z_follows_depth, i_clk, i_rst_n, o_strobe, o_point_z == $past(w_z_in, LAT))
    `DPBP_ASSERT_SAME(a_red_follows, i_clk, i_rst_n, o_strobe, o_red_out == $past(i_red_in, LAT))

endmodule

bind depth_pixel_backprojection_unit dpbp_chk #(
    .DEPTH_BITS (DEPTH_BITS)
) u_dpbp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_depth_raw (i_depth_raw),
    .i_red_in    (i_red_in),
    .o_strobe    (o_strobe),
    .o_point_z   (o_point_z),
    .o_red_out   (o_red_out)
);
